@@ rtl/sbe_pkg.sv @@
// Package for the stack bytecode executor: opcodes, event kinds, widths.
// No dependencies.
`timescale 1ns / 1ps
package sbe_pkg;
	localparam int STACK_DEPTH_DEF   = 64;
	localparam int NUM_VARIABLES_DEF = 2;
	localparam int NUM_DEVICES_DEF   = 16;
	localparam int PC_BITS_DEF       = 16;
	localparam int CFG_W             = 16;
	localparam int CFG_IDX_W         = 1;

	localparam logic [7:0] OP_PUSH  = 8'h01;
	localparam logic [7:0] OP_ADD   = 8'h02;
	localparam logic [7:0] OP_SUB   = 8'h03;
	localparam logic [7:0] OP_MUL   = 8'h04;
	localparam logic [7:0] OP_DIV   = 8'h05;
	localparam logic [7:0] OP_MOD   = 8'h06;
	localparam logic [7:0] OP_LOAD  = 8'h07;
	localparam logic [7:0] OP_STORE = 8'h08;
	localparam logic [7:0] OP_JMP   = 8'h09;
	localparam logic [7:0] OP_JZ    = 8'h0A;
	localparam logic [7:0] OP_JNZ   = 8'h0B;
	localparam logic [7:0] OP_PRINT = 8'h0E;
	localparam logic [7:0] OP_IORD  = 8'h0F;
	localparam logic [7:0] OP_IOWR  = 8'h10;
	localparam logic [7:0] OP_WAIT  = 8'h18;
	localparam logic [7:0] OP_HALT  = 8'hFF;

	localparam logic [CFG_IDX_W-1:0] REG_RD_MASK = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WR_MASK = 1'd1;

	localparam logic [2:0] EV_NONE  = 3'd0;
	localparam logic [2:0] EV_PRINT = 3'd1;
	localparam logic [2:0] EV_DRD   = 3'd2;
	localparam logic [2:0] EV_DWR   = 3'd3;
	localparam logic [2:0] EV_WAIT  = 3'd4;

	typedef struct packed {
		logic [7:0]         opcode;
		logic signed [31:0] operand;
		logic signed [31:0] device_read_data;
	} in_item_t;

	typedef struct packed {
		logic [15:0]        next_pc;
		logic               halted;
		logic [2:0]         event_kind;
		logic signed [31:0] event_value;
		logic [3:0]         event_device;
	} out_item_t;
endpackage

@@ rtl/sbe_if.sv @@
// Valid/ready channel interfaces for the executor.
// Depends on sbe_pkg.
`timescale 1ns / 1ps
interface sbe_in_if;
	import sbe_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sbe_out_if;
	import sbe_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/stack_bytecode_executor.sv @@
// Top level of the stack bytecode executor.
// Depends on sbe_pkg, sbe_if (channels) and sbe_ram (operand stack).
//
//  channel | dir | contents
//  in_ch   | in  | opcode, operand, device_read_data
//  out_ch  | out | next_pc, halted, event_kind, event_value, event_device
//  cfg     | in  | cfg_we, cfg_idx, cfg_data (read/write device masks)
//
// An item passes through these steps in order: accept in idle, read of the top entry,
// read of the second entry, execute. Multiply adds a step before execute; div/mod
// first run a 1-bit-per-cycle restoring divider, which ends early for a zero divisor.
// The registered stack RAM read port is what makes the two reads separate steps.
// Reset clears pc, depth, halt, variables and masks; no clearing pass.
// A result waits in the output register; the next item is still taken and
// read, and its execute cycle stalls until the waiting result is transferred.
`timescale 1ns / 1ps
module stack_bytecode_executor #(
	parameter int STACK_DEPTH   = sbe_pkg::STACK_DEPTH_DEF,
	parameter int NUM_VARIABLES = sbe_pkg::NUM_VARIABLES_DEF,
	parameter int NUM_DEVICES   = sbe_pkg::NUM_DEVICES_DEF,
	parameter int PC_BITS       = sbe_pkg::PC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	sbe_in_if.sink                         in_ch,
	sbe_out_if.source                      out_ch,
	input  logic                           cfg_we,
	input  logic [sbe_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [sbe_pkg::CFG_W-1:0]      cfg_data
);
	import sbe_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam int VW = (NUM_VARIABLES > 1) ? $clog2(NUM_VARIABLES) : 1;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_RD1  = 6'b000010,
		ST_RD2  = 6'b000100,
		ST_EXEC = 6'b001000,
		ST_MUL  = 6'b010000,
		ST_DIV  = 6'b100000
	} state_t;

	state_t             state_q;
	in_item_t           item_q;
	logic [DW-1:0]      depth_q;
	logic [PC_BITS-1:0] pc_q;
	logic               halt_q;
	logic [CFG_W-1:0]   rd_mask_q, wr_mask_q;
	logic [31:0]        vars_q [NUM_VARIABLES];
	logic [31:0]        top_q;
	logic               out_valid_q;
	out_item_t          out_q;
	logic [31:0]        prod_q;
	// divider
	logic [31:0]        dq_q, dr_q, dd_q;
	logic [5:0]         dcnt_q;
	logic               dneg_q, dwant_rem_q;

	// stack RAM
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [31:0]   ram_wdata, ram_rdata;

	sbe_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	// operands: b = top, a = second; zero when absent
	logic [31:0] b_val, a_val;
	assign b_val = (depth_q >= DW'(1)) ? top_q : 32'd0;
	assign a_val = (depth_q >= DW'(2)) ? ram_rdata : 32'd0;

	always_comb begin
		ram_raddr = '0;
		if (state_q == ST_IDLE || state_q == ST_RD1) begin
			if (depth_q >= DW'(1)) ram_raddr = AW'(depth_q - DW'(1));
		end
		if (state_q == ST_RD2 || state_q == ST_EXEC || state_q == ST_MUL
			|| state_q == ST_DIV) begin
			if (depth_q >= DW'(2)) ram_raddr = AW'(depth_q - DW'(2));
		end
	end

	// execute commits once the output register is free
	logic do_exec;
	assign do_exec = (state_q == ST_EXEC) && (!out_valid_q || out_ch.ready);

	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

	// divider helpers
	logic [31:0] abs_a, abs_b;
	assign abs_a = a_val[31] ? (32'd0 - a_val) : a_val;
	assign abs_b = b_val[31] ? (32'd0 - b_val) : b_val;
	logic [32:0] dtrial;
	assign dtrial = {dr_q, dq_q[31]} - {1'b0, dd_q};

	// execution
	logic [7:0]         op;
	logic [7:0]         vidx8;
	logic [31:0]        off;
	logic [PC_BITS-1:0] pc_n;
	logic [DW-1:0]      depth_n;
	logic               push;
	logic [31:0]        push_v;
	logic [2:0]         kind;
	logic [31:0]        ev;
	logic [3:0]         edev;
	logic               halt_n;
	logic               var_we;
	logic [31:0]        div_res;
	logic [DW-1:0]      d1;

	assign op    = item_q.opcode;
	assign vidx8 = item_q.operand[7:0];
	assign off   = {{16{item_q.operand[15]}}, item_q.operand[15:0]};
	assign d1    = (depth_q >= DW'(1)) ? depth_q - DW'(1) : depth_q;
	// zero divisor gives 0 for both div and mod
	assign div_res = (b_val == 32'd0) ? 32'd0
		: dwant_rem_q ? (dneg_q ? 32'd0 - dr_q : dr_q)
		: (dneg_q ? 32'd0 - dq_q : dq_q);

	always_comb begin
		logic [DW-1:0] d2;
		d2      = (d1 >= DW'(1)) ? d1 - DW'(1) : d1;
		pc_n    = pc_q + PC_BITS'(1);
		depth_n = depth_q;
		push    = 1'b0;
		push_v  = 32'd0;
		kind    = EV_NONE;
		ev      = 32'd0;
		edev    = 4'd0;
		halt_n  = 1'b0;
		var_we  = 1'b0;
		case (op)
			OP_PUSH: begin
				pc_n = pc_q + PC_BITS'(5); push = 1'b1; push_v = item_q.operand;
			end
			OP_ADD: begin depth_n = d2; push = 1'b1; push_v = a_val + b_val; end
			OP_SUB: begin depth_n = d2; push = 1'b1; push_v = a_val - b_val; end
			OP_MUL: begin depth_n = d2; push = 1'b1; push_v = prod_q; end
			OP_DIV, OP_MOD: begin depth_n = d2; push = 1'b1; push_v = div_res; end
			OP_LOAD: begin
				pc_n = pc_q + PC_BITS'(2);
				if (32'(vidx8) < NUM_VARIABLES) begin
					push = 1'b1; push_v = vars_q[VW'(vidx8)];
				end
			end
			OP_STORE: begin
				pc_n = pc_q + PC_BITS'(2);
				if (32'(vidx8) < NUM_VARIABLES) begin
					depth_n = d1; var_we = 1'b1;
				end
			end
			OP_JMP: pc_n = pc_q + PC_BITS'(3) + PC_BITS'(off);
			OP_JZ: begin
				depth_n = d1;
				pc_n = pc_q + PC_BITS'(3) + ((b_val == 32'd0) ? PC_BITS'(off) : '0);
			end
			OP_JNZ: begin
				depth_n = d1;
				pc_n = pc_q + PC_BITS'(3) + ((b_val != 32'd0) ? PC_BITS'(off) : '0);
			end
			OP_PRINT: begin depth_n = d1; kind = EV_PRINT; ev = b_val; end
			OP_IORD: begin
				depth_n = d1; push = 1'b1;
				if (32'(b_val[7:0]) < NUM_DEVICES && b_val[7:4] == 4'd0
					&& rd_mask_q[b_val[3:0]]) begin
					push_v = item_q.device_read_data; kind = EV_DRD;
					ev = item_q.device_read_data; edev = b_val[3:0];
				end
			end
			OP_IOWR: begin
				depth_n = d2;
				if (32'(a_val[7:0]) < NUM_DEVICES && a_val[7:4] == 4'd0
					&& wr_mask_q[a_val[3:0]]) begin
					kind = EV_DWR; ev = b_val; edev = a_val[3:0];
				end
			end
			OP_WAIT: begin
				depth_n = d1;
				if (b_val != 32'd0 && !b_val[31]) begin kind = EV_WAIT; ev = b_val; end
			end
			OP_HALT: halt_n = 1'b1;
			default: ;
		endcase
	end

	assign ram_we    = do_exec && !halt_q && push && (depth_n < DW'(STACK_DEPTH));
	assign ram_waddr = AW'(depth_n);
	assign ram_wdata = push_v;

	// registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			depth_q     <= '0;
			pc_q        <= '0;
			halt_q      <= 1'b0;
			rd_mask_q   <= '0;
			wr_mask_q   <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_VARIABLES; i++) vars_q[i] <= 32'd0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == REG_RD_MASK) rd_mask_q <= cfg_data;
				if (cfg_idx == REG_WR_MASK) wr_mask_q <= cfg_data;
			end
			if (do_exec) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ch.ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (in_ch.valid && in_ch.ready) state_q <= ST_RD1;
				ST_RD1: state_q <= ST_RD2;
				ST_RD2: begin
					if (item_q.opcode == OP_MUL) state_q <= ST_MUL;
					else if (item_q.opcode == OP_DIV || item_q.opcode == OP_MOD)
						state_q <= ST_DIV;
					else state_q <= ST_EXEC;
				end
				ST_MUL: state_q <= ST_EXEC;
				ST_DIV: if (dcnt_q == 6'd32) state_q <= ST_EXEC;
				ST_EXEC: begin
					if (do_exec) begin
						state_q <= ST_IDLE;
						if (!halt_q) begin
							pc_q    <= pc_n;
							halt_q  <= halt_n;
							depth_q <= (push && depth_n < DW'(STACK_DEPTH))
								? depth_n + DW'(1) : depth_n;
							if (var_we) vars_q[VW'(vidx8)] <= b_val;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) item_q <= in_ch.data;
		if (state_q == ST_RD2) top_q <= ram_rdata;
		if (state_q == ST_MUL) prod_q <= a_val * b_val;
		if (state_q == ST_RD2) begin
			dcnt_q      <= '0;
			dwant_rem_q <= (item_q.opcode == OP_MOD);
		end
		if (state_q == ST_DIV) begin
			if (dcnt_q == 6'd0) begin
				dq_q   <= abs_a;
				dr_q   <= 32'd0;
				dd_q   <= abs_b;
				dneg_q <= dwant_rem_q ? a_val[31] : (a_val[31] ^ b_val[31]);
				if (b_val == 32'd0) dcnt_q <= 6'd32;
				else dcnt_q <= 6'd1;
			end else begin
				if (!dtrial[32]) begin
					dr_q <= dtrial[31:0];
					dq_q <= {dq_q[30:0], 1'b1};
				end else begin
					dr_q <= {dr_q[30:0], dq_q[31]};
					dq_q <= {dq_q[30:0], 1'b0};
				end
				dcnt_q <= dcnt_q + 6'd1;
			end
		end
		if (do_exec) begin
			out_q.next_pc      <= 16'(halt_q ? pc_q : pc_n);
			out_q.halted       <= halt_q | halt_n;
			out_q.event_kind   <= halt_q ? EV_NONE : kind;
			out_q.event_value  <= halt_q ? 32'd0 : ev;
			out_q.event_device <= halt_q ? 4'd0 : edev;
		end
	end

	// checks
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ch.ready) else $error("accept while busy");
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(STACK_DEPTH)) else $error("stack depth overflow");
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q) else $error("halt flag cleared");
	a_exec_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC) |=> out_valid_q) else $error("result missing");
endmodule

@@ rtl/sbe_ram.sv @@
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module sbe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
